/* hdl/utf8_text_normalizer_unit_defines.svh */
// Assertion macros for the text normalizer.
`ifndef UTF8_TEXT_NORMALIZER_UNIT_DEFINES_SVH
`define UTF8_TEXT_NORMALIZER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define UTN_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("utn check failed");
`define UTN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("utn check failed");
`else
`define UTN_ASSERT_SAME(label, clk, rst, ante, cons)
`define UTN_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* hdl/utn_pkg.sv */
// Shared types, constants and helpers for the text normalizer.
`timescale 1ns / 1ps
package utn_pkg;

  localparam int FIFO_DEPTH_DEFAULT = 4;

  localparam logic [7:0] SPACE_BYTE  = 8'h20;
  localparam logic [7:0] CASE_OFFSET = 8'h20;
  localparam logic [7:0] LEAD_CYR    = 8'hD0;
  localparam logic [7:0] LEAD_GRK    = 8'hCE;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [7:0] b0;
    logic [7:0] b1;
    logic       two;
    logic       v0;
    logic       last;
  } cmd_t;

  function automatic logic is_separator(input logic [7:0] c);
    logic r;
    r = (c inside {8'h20, [8'h09:8'h0D], [8'h21:8'h2F], [8'h3A:8'h40],
                   [8'h5B:8'h60], [8'h7B:8'h7E]});
    return r;
  endfunction

  function automatic logic [7:0] fold_second(input logic [7:0] lead,
                                             input logic [7:0] c2);
    logic [7:0] r;
    r = c2;
    if (lead == LEAD_CYR && (c2 inside {[8'h90:8'hAF]})) begin
      r = c2 + CASE_OFFSET;
    end else if (lead == LEAD_GRK && (c2 inside {[8'h91:8'hAB]})) begin
      r = c2 + CASE_OFFSET;
    end
    return r;
  endfunction

endpackage

/* hdl/utn_front.sv */
// Front end: decodes each input word and builds a queue command.
`timescale 1ns / 1ps
module utn_front import utn_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     accept,
  input  in_word_t in_data,
  output logic     push,
  output cmd_t     cmd
);

  logic       at_boundary, at_boundary_next;
  logic       space_pending, space_pending_next;
  logic       lead_held, lead_held_next;
  logic [7:0] held_lead_byte, held_lead_byte_next;
  logic [1:0] copy_remaining, copy_remaining_next;

  logic [7:0] b;
  logic       eot;
  logic       lead2, lead3, lead4;
  logic       emit_ch;
  logic [7:0] ch_byte;
  logic [1:0] n;

  assign b     = in_data.in_byte;
  assign eot   = in_data.end_of_text;
  assign lead2 = (b[7:5] == 3'b110);
  assign lead3 = (b[7:4] == 4'b1110);
  assign lead4 = (b[7:3] == 5'b11110);

  always_comb begin
    at_boundary_next    = at_boundary;
    space_pending_next  = space_pending;
    lead_held_next      = lead_held;
    held_lead_byte_next = held_lead_byte;
    copy_remaining_next = copy_remaining;
    cmd                 = '{b0: 8'h00, b1: 8'h00, two: 1'b0, v0: 1'b1, last: eot};
    n                   = 2'd0;
    emit_ch             = 1'b0;
    ch_byte             = b;

    if (lead_held) begin
      cmd.b0              = held_lead_byte;
      cmd.b1              = fold_second(held_lead_byte, b);
      n                   = 2'd2;
      lead_held_next      = 1'b0;
      held_lead_byte_next = 8'h00;
    end else if (copy_remaining != 2'd0) begin
      cmd.b0              = b;
      n                   = 2'd1;
      copy_remaining_next = copy_remaining - 2'd1;
    end else if (is_separator(b)) begin
      if (!at_boundary) begin
        space_pending_next = 1'b1;
        at_boundary_next   = 1'b1;
      end
    end else begin
      at_boundary_next   = 1'b0;
      space_pending_next = 1'b0;
      emit_ch            = !lead2 || eot;
      if (!(lead2 || lead3 || lead4) && (b inside {[8'h41:8'h5A]})) begin
        ch_byte = b + CASE_OFFSET;
      end
      if (lead2) begin
        lead_held_next      = 1'b1;
        held_lead_byte_next = b;
      end
      if (lead3) begin
        copy_remaining_next = 2'd2;
      end else if (lead4) begin
        copy_remaining_next = 2'd3;
      end
      if (space_pending) begin
        cmd.b0 = SPACE_BYTE;
        cmd.b1 = ch_byte;
        n      = emit_ch ? 2'd2 : 2'd1;
      end else begin
        cmd.b0 = ch_byte;
        n      = emit_ch ? 2'd1 : 2'd0;
      end
    end

    if (eot && n == 2'd0) begin
      cmd.b0 = 8'h00;
      cmd.v0 = 1'b0;
      n      = 2'd1;
    end
    cmd.two = (n == 2'd2);
  end

  assign push = accept && (n != 2'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      at_boundary    <= 1'b1;
      space_pending  <= 1'b0;
      lead_held      <= 1'b0;
      held_lead_byte <= 8'h00;
      copy_remaining <= 2'd0;
    end else if (accept) begin
      if (eot) begin
        at_boundary    <= 1'b1;
        space_pending  <= 1'b0;
        lead_held      <= 1'b0;
        held_lead_byte <= 8'h00;
        copy_remaining <= 2'd0;
      end else begin
        at_boundary    <= at_boundary_next;
        space_pending  <= space_pending_next;
        lead_held      <= lead_held_next;
        held_lead_byte <= held_lead_byte_next;
        copy_remaining <= copy_remaining_next;
      end
    end
  end

endmodule

/* hdl/utn_fifo.sv */
// Command queue between the front end and the back end.
`timescale 1ns / 1ps
module utn_fifo import utn_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  input  logic pop,
  output logic full,
  output logic head_valid,
  output cmd_t head_cmd
);

  localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  cmd_t             slots [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full       = (count == CNT_W'(FIFO_DEPTH));
  assign head_valid = (count != '0);
  assign head_cmd   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hdl/utn_back.sv */
// Back end: unpacks queue commands into single output words.
`timescale 1ns / 1ps
module utn_back import utn_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  cmd_t      head_cmd,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic phase;
  logic load;
  logic final_part;

  assign load       = head_valid && (!out_valid || out_ready);
  assign final_part = !head_cmd.two || phase;
  assign pop        = load && final_part;

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.out_byte   <= phase ? head_cmd.b1 : head_cmd.b0;
      out_data.byte_valid <= phase ? 1'b1 : head_cmd.v0;
      out_data.last       <= head_cmd.last && final_part;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !final_part;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* hdl/utf8_text_normalizer_unit.sv */
// A word is written into the command queue and then loaded into the output register.
// Throughput: one input word per cycle while the queue has room; the back end sends one
// output word per cycle unless out_ready stalls, so a two-word input holds it for both.
// The command queue (FIFO_DEPTH entries) absorbs that and output stalls.
// Reset clears the decode state, empties the queue and drops the output register.
`timescale 1ns / 1ps
`include "utf8_text_normalizer_unit_defines.svh"
module utf8_text_normalizer_unit import utn_pkg::*; #(
  parameter int FIFO_DEPTH = FIFO_DEPTH_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_word_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_word_t out_data
);

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic full;
  logic head_valid;
  cmd_t head_cmd;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;

  utn_front u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .push    (push),
    .cmd     (push_cmd)
  );

  utn_fifo #(
    .FIFO_DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .pop        (pop),
    .full       (full),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  utn_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  `UTN_ASSERT_SAME(a_eot_pushes, clk, rst, accept && in_data.end_of_text, push)
  `UTN_ASSERT_SAME(a_bare_is_last, clk, rst, out_valid && !out_data.byte_valid, out_data.last)
  `UTN_ASSERT_SAME(a_pop_has_head, clk, rst, pop, head_valid)
  `UTN_ASSERT_NEXT(a_push_lands, clk, rst, push && !pop, head_valid)

endmodule

/* sim/utf8_text_normalizer_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for the UTF-8 text normalizer: directed and random texts checked word by word.
module utf8_text_normalizer_unit_tb;
  import utn_pkg::*;

  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_WORDS  = 290;
  localparam int HOLD_CYCLES  = 300;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  int fail_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int words_sent = 0;

  out_word_t  expected_words[$];
  logic [7:0] text_bytes[$];

  logic       in_gap = 1'b1;
  logic       space_owed = 1'b0;
  logic       pair_lead_valid = 1'b0;
  logic [7:0] pair_lead = 8'h00;
  logic [1:0] tail_left = 2'd0;

  utf8_text_normalizer_unit u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : check_output
    out_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output word: out_byte %h byte_valid %b last %b",
               out_data.out_byte, out_data.byte_valid, out_data.last);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $error("out_byte: expected %h, actual %h", want.out_byte, out_data.out_byte);
          fail_count++;
        end
        if (out_data.byte_valid !== want.byte_valid) begin
          $error("byte_valid: expected %b, actual %b", want.byte_valid,
                 out_data.byte_valid);
          fail_count++;
        end
        if (out_data.last !== want.last) begin
          $error("last: expected %b, actual %b", want.last, out_data.last);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic ascii_break(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D) || (c >= 8'h21 && c <= 8'h2F) ||
           (c >= 8'h3A && c <= 8'h40) || (c >= 8'h5B && c <= 8'h60) ||
           (c >= 8'h7B && c <= 8'h7E);
  endfunction

  function automatic int utf8_span(input logic [7:0] c);
    if (c < 8'h80) return 1;
    if ((c & 8'hE0) == 8'hC0) return 2;
    if ((c & 8'hF0) == 8'hE0) return 3;
    if ((c & 8'hF8) == 8'hF0) return 4;
    return 1;
  endfunction

  function automatic logic [7:0] fold_pair(input logic [7:0] lead, input logic [7:0] c2);
    if (lead == LEAD_CYR && c2 >= 8'h90 && c2 <= 8'hAF) return c2 + CASE_OFFSET;
    if (lead == LEAD_GRK && c2 >= 8'h91 && c2 <= 8'hAB) return c2 + CASE_OFFSET;
    return c2;
  endfunction

  function automatic out_word_t norm_word(input logic [7:0] b, input logic v);
    out_word_t w;
    w.out_byte = b;
    w.byte_valid = v;
    w.last = 1'b0;
    return w;
  endfunction

  task automatic clear_text_state();
    in_gap = 1'b1;
    space_owed = 1'b0;
    pair_lead_valid = 1'b0;
    pair_lead = 8'h00;
    tail_left = 2'd0;
  endtask

  task automatic predict_word(input logic [7:0] b, input logic eot);
    out_word_t step_words[$];
    out_word_t tail;
    int span;
    span = utf8_span(b);
    if (pair_lead_valid) begin
      step_words.push_back(norm_word(pair_lead, 1'b1));
      step_words.push_back(norm_word(fold_pair(pair_lead, b), 1'b1));
      pair_lead_valid = 1'b0;
      pair_lead = 8'h00;
    end else if (tail_left != 2'd0) begin
      step_words.push_back(norm_word(b, 1'b1));
      tail_left = tail_left - 2'd1;
    end else if (span == 1 && b < 8'h80 && ascii_break(b)) begin
      if (!in_gap) begin
        space_owed = 1'b1;
        in_gap = 1'b1;
      end
    end else begin
      if (space_owed) begin
        step_words.push_back(norm_word(SPACE_BYTE, 1'b1));
        space_owed = 1'b0;
      end
      in_gap = 1'b0;
      if (span == 1) begin
        step_words.push_back(norm_word((b >= 8'h41 && b <= 8'h5A) ? b + CASE_OFFSET : b,
                                       1'b1));
      end else if (span == 2) begin
        pair_lead_valid = 1'b1;
        pair_lead = b;
      end else begin
        step_words.push_back(norm_word(b, 1'b1));
        tail_left = 2'(span - 1);
      end
    end
    if (eot) begin
      if (pair_lead_valid) step_words.push_back(norm_word(pair_lead, 1'b1));
      if (step_words.size() == 0) step_words.push_back(norm_word(8'h00, 1'b0));
      tail = step_words.pop_back();
      tail.last = 1'b1;
      step_words.push_back(tail);
      clear_text_state();
    end
    foreach (step_words[i]) expected_words.push_back(step_words[i]);
  endtask

  task automatic send_word(input logic [7:0] b, input logic eot);
    in_word_t w;
    w.in_byte = b;
    w.end_of_text = eot;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(b, eot);
    words_sent++;
  endtask

  function automatic logic [7:0] pick_separator();
    case ($urandom_range(4))
      0: return 8'h20;
      1: return 8'($urandom_range(8'h0D, 8'h09));
      2: return 8'($urandom_range(8'h2F, 8'h21));
      3: return 8'($urandom_range(8'h40, 8'h3A));
      default: return $urandom_range(1) ? 8'($urandom_range(8'h60, 8'h5B))
                                         : 8'($urandom_range(8'h7E, 8'h7B));
    endcase
  endfunction

  function automatic logic [7:0] body_byte();
    if ($urandom_range(4) == 0) return 8'($urandom_range(255));
    return 8'($urandom_range(8'hBF, 8'h80));
  endfunction

  task automatic add_char(input bit favor_pairs);
    int kind;
    logic [7:0] c;
    kind = $urandom_range(99);
    if (favor_pairs && kind < 70) kind = 60;
    if (kind < 25) begin
      c = $urandom_range(1) ? 8'($urandom_range(8'h5A, 8'h41))
                            : 8'($urandom_range(8'h7A, 8'h61));
      text_bytes.push_back(c);
    end else if (kind < 35) begin
      c = 8'($urandom_range(8'h7F));
      text_bytes.push_back(c);
    end else if (kind < 55) begin
      text_bytes.push_back(pick_separator());
    end else if (kind < 72) begin
      case ($urandom_range(3))
        0: c = LEAD_CYR;
        1: c = LEAD_GRK;
        default: c = 8'($urandom_range(8'hDF, 8'hC0));
      endcase
      text_bytes.push_back(c);
      text_bytes.push_back(body_byte());
    end else if (kind < 82) begin
      c = 8'($urandom_range(8'hEF, 8'hE0));
      text_bytes.push_back(c);
      repeat (2) text_bytes.push_back(body_byte());
    end else if (kind < 90) begin
      c = 8'($urandom_range(8'hF7, 8'hF0));
      text_bytes.push_back(c);
      repeat (3) text_bytes.push_back(body_byte());
    end else if (kind < 95) begin
      c = $urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                            : 8'($urandom_range(8'hFF, 8'hF8));
      text_bytes.push_back(c);
    end else begin
      c = 8'($urandom_range(255));
      text_bytes.push_back(c);
    end
  endtask

  task automatic send_text(input bit favor_pairs);
    int nchars;
    text_bytes.delete();
    nchars = $urandom_range(14, 1);
    repeat (nchars) add_char(favor_pairs);
    // cut the tail now and then to break the last sequence
    if (text_bytes.size() > 1 && $urandom_range(7) == 0) void'(text_bytes.pop_back());
    foreach (text_bytes[i]) send_word(text_bytes[i], i == text_bytes.size() - 1);
  endtask

  task automatic run_texts(input int count, input bit favor_pairs);
    int target;
    target = words_sent + count;
    while (words_sent < target) send_text(favor_pairs);
  endtask

  task automatic test_directed();
    logic [8:0] seq[$];
    send_idle_pct = 0;
    stall_pct = 0;
    seq = '{9'h020, 9'h041, 9'h02C, 9'h009, 9'h05A, 9'h000, 9'h0D0, 9'h090, 9'h0CE,
            9'h0AB, 9'h0E2, 9'h020, 9'h0C3, 9'h0F0, 9'h080, 9'h0FF, 9'h041, 9'h080,
            9'h0FF, 9'h07E, 9'h121, 9'h1D0, 9'h061, 9'h0E0, 9'h180};
    foreach (seq[i]) send_word(seq[i][7:0], seq[i][8]);
  endtask

  task automatic test_no_idle();
    send_idle_pct = 0;
    stall_pct = 0;
    run_texts(PHASE_WORDS, 1'b0);
  endtask

  task automatic test_sender_idle();
    send_idle_pct = 83;
    stall_pct = 0;
    run_texts(PHASE_WORDS, 1'b0);
  endtask

  task automatic test_receiver_stall();
    send_idle_pct = 0;
    stall_pct = 83;
    run_texts(PHASE_WORDS, 1'b0);
  endtask

  task automatic test_both_idle();
    send_idle_pct = 26;
    stall_pct = 26;
    run_texts(PHASE_WORDS, 1'b0);
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    hold_left <= HOLD_CYCLES;
    run_texts(60, 1'b1);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_no_idle();
    test_sender_idle();
    test_receiver_stall();
    test_both_idle();
    test_backpressure();
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
